// ----- src/fsc_pkg.sv -----
// Shared types, widths and plane tables for the frustum sphere cull block.
// Used by every module in src; depends on nothing.
package fsc_pkg;

    localparam int NUM_PLANES    = 6;
    localparam int NUM_ROWS      = 4;
    localparam int NUM_CFG       = 8;
    localparam int CFG_IDX_W     = 8;
    localparam int CFG_W         = 64;
    localparam int ENT_W         = 32;
    localparam int COEF_W        = ENT_W + 1;
    localparam int SQ_W          = 2 * ENT_W + 1;
    localparam int NORM_W        = SQ_W + 1;
    localparam int CTR_W         = 32;
    localparam int RAD_W         = 31;
    localparam int RAD2_W        = 2 * RAD_W;
    localparam int DOT_W         = 67;
    localparam int MAG_W         = DOT_W - 1;
    localparam int HALF_W        = MAG_W / 2;
    localparam int PART_W        = 2 * HALF_W;
    localparam int D2_W          = 2 * MAG_W;
    localparam int LHS_W         = RAD2_W + NORM_W;
    localparam int FRAC_BITS_DEF = 16;
    localparam int SETTLE        = 3;
    localparam int SETTLE_W      = 2;
    localparam int PLANE_LAT     = 6;

    typedef logic signed [COEF_W-1:0] coef_t;
    typedef logic        [NORM_W-1:0] norm_t;

    // Plane order: left, right, bottom, top, near, far.
    localparam bit PLANE_W4  [NUM_PLANES] = '{1'b1, 1'b1, 1'b1, 1'b1, 1'b0, 1'b1};
    localparam bit PLANE_NEG [NUM_PLANES] = '{1'b0, 1'b1, 1'b0, 1'b1, 1'b0, 1'b1};
    localparam int PLANE_COL [NUM_PLANES] = '{0, 0, 1, 1, 2, 2};

    localparam logic [CFG_W-1:0] CFG_RESET [NUM_CFG] = '{
        64'h0000_0000_0001_0000, 64'h0,
        64'h0001_0000_0000_0000, 64'h0,
        64'h0,                   64'h0000_0000_0001_0000,
        64'h0,                   64'h0001_0000_0000_0000
    };

endpackage

// ----- src/fsc_coef.sv -----
// Matrix registers and the plane coefficients and squared norms derived from them.
// Depends on fsc_pkg.
module fsc_coef
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               wr_en,
    input  logic [fsc_pkg::CFG_IDX_W-1:0]      wr_index,
    input  logic [fsc_pkg::CFG_W-1:0]          wr_data,
    output fsc_pkg::coef_t                     coef [fsc_pkg::NUM_PLANES][fsc_pkg::NUM_ROWS],
    output fsc_pkg::norm_t                     norm [fsc_pkg::NUM_PLANES],
    output logic                               busy
);

    logic [fsc_pkg::CFG_W-1:0]  cfg_reg [fsc_pkg::NUM_CFG];
    fsc_pkg::coef_t             k_reg   [fsc_pkg::NUM_PLANES][fsc_pkg::NUM_ROWS];
    logic [fsc_pkg::SQ_W-1:0]   sq_reg  [fsc_pkg::NUM_PLANES][3];
    fsc_pkg::norm_t             s_reg   [fsc_pkg::NUM_PLANES];
    logic [fsc_pkg::SETTLE_W-1:0] settle_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < fsc_pkg::NUM_CFG; i++)
            begin
                cfg_reg[i] <= fsc_pkg::CFG_RESET[i];
            end
            settle_reg <= fsc_pkg::SETTLE_W'(fsc_pkg::SETTLE);
        end
        else if (wr_en)
        begin
            if (wr_index < fsc_pkg::CFG_IDX_W'(fsc_pkg::NUM_CFG))
            begin
                cfg_reg[wr_index[2:0]] <= wr_data;
            end
            settle_reg <= fsc_pkg::SETTLE_W'(fsc_pkg::SETTLE);
        end
        else if (settle_reg != '0)
        begin
            settle_reg <= settle_reg - 1'b1;
        end
    end

    genvar p, r;
    generate
        for (p = 0; p < fsc_pkg::NUM_PLANES; p++)
        begin : g_plane
            for (r = 0; r < fsc_pkg::NUM_ROWS; r++)
            begin : g_row
                logic [fsc_pkg::CFG_W-1:0] reg_w;
                logic [fsc_pkg::CFG_W-1:0] reg_c;
                logic signed [fsc_pkg::COEF_W-1:0] w_ent;
                logic signed [fsc_pkg::COEF_W-1:0] c_ent;

                assign reg_w = cfg_reg[2 * r + 1];
                assign reg_c = cfg_reg[2 * r + fsc_pkg::PLANE_COL[p] / 2];
                assign w_ent = fsc_pkg::PLANE_W4[p]
                             ? fsc_pkg::COEF_W'($signed(reg_w[63:32])) : '0;
                assign c_ent = (fsc_pkg::PLANE_COL[p] % 2 == 1)
                             ? fsc_pkg::COEF_W'($signed(reg_c[63:32]))
                             : fsc_pkg::COEF_W'($signed(reg_c[31:0]));

                always_ff @(posedge clk)
                begin
                    k_reg[p][r] <= fsc_pkg::PLANE_NEG[p] ? (w_ent - c_ent) : (w_ent + c_ent);
                end

                if (r < 3)
                begin : g_sq
                    logic signed [2*fsc_pkg::COEF_W-1:0] sq_full;
                    assign sq_full = k_reg[p][r] * k_reg[p][r];
                    always_ff @(posedge clk)
                    begin
                        sq_reg[p][r] <= sq_full[fsc_pkg::SQ_W-1:0];
                    end
                end
            end

            always_ff @(posedge clk)
            begin
                s_reg[p] <= fsc_pkg::NORM_W'(sq_reg[p][0]) + fsc_pkg::NORM_W'(sq_reg[p][1])
                          + fsc_pkg::NORM_W'(sq_reg[p][2]);
            end

            assign norm[p] = s_reg[p];
            for (r = 0; r < fsc_pkg::NUM_ROWS; r++)
            begin : g_out
                assign coef[p][r] = k_reg[p][r];
            end
        end
    endgenerate

    assign busy = (settle_reg != '0);

endmodule

// ----- src/fsc_plane.sv -----
// Exact sphere-behind-plane test for one plane, six register stages deep.
// Depends on fsc_pkg; coefficients come from fsc_coef.
module fsc_plane
#(
    parameter int FRAC_BITS = fsc_pkg::FRAC_BITS_DEF
)
(
    input  logic                               clk,
    input  logic                               adv,
    input  fsc_pkg::coef_t                     k [fsc_pkg::NUM_ROWS],
    input  fsc_pkg::norm_t                     s,
    input  logic signed [fsc_pkg::CTR_W-1:0]   cx,
    input  logic signed [fsc_pkg::CTR_W-1:0]   cy,
    input  logic signed [fsc_pkg::CTR_W-1:0]   cz,
    input  logic        [fsc_pkg::RAD_W-1:0]   rad,
    output logic                               cull
);

    localparam int PRD_W = fsc_pkg::COEF_W + fsc_pkg::CTR_W;
    localparam int HW    = fsc_pkg::HALF_W;
    localparam int RH_W  = fsc_pkg::RAD_W;
    localparam int SH_W  = fsc_pkg::NORM_W / 2;
    localparam int PP_W  = RH_W + SH_W;

    // Stage 1: center products, shifted constant term, radius squared.
    logic signed [PRD_W-1:0]            p0_reg, p1_reg, p2_reg;
    logic signed [fsc_pkg::DOT_W-1:0]   kd_reg;
    logic [fsc_pkg::RAD2_W-1:0]         rad2_1_reg;
    // Stage 2: plane distance.
    logic signed [fsc_pkg::DOT_W-1:0]   dot_reg;
    logic [fsc_pkg::RAD2_W-1:0]         rad2_2_reg;
    // Stage 3: magnitude and sign.
    logic [fsc_pkg::MAG_W-1:0]          mag_reg;
    logic                               neg3_reg;
    logic [fsc_pkg::RAD2_W-1:0]         rad2_3_reg;
    // Stage 4: partial products.
    logic [fsc_pkg::PART_W-1:0]         ll_reg, hl_reg, hh_reg;
    logic [PP_W-1:0]                    rlsl_reg, rlsh_reg, rhsl_reg, rhsh_reg;
    logic                               neg4_reg;
    // Stage 5: both squares assembled.
    logic [fsc_pkg::D2_W-1:0]           d2_reg;
    logic [fsc_pkg::LHS_W-1:0]          lhs_reg;
    logic                               neg5_reg;
    // Stage 6: verdict.
    logic                               cull_reg;

    logic signed [fsc_pkg::DOT_W-1:0]   k3x;
    logic [2*RH_W-1:0]                  rad2_full;
    logic [fsc_pkg::DOT_W-1:0]          dot_abs;
    logic [HW-1:0]                      dl, dh;
    logic [RH_W-1:0]                    rl, rh;
    logic [SH_W-1:0]                    sl, sh;

    assign k3x       = fsc_pkg::DOT_W'(k[3]);
    assign rad2_full = rad * rad;
    assign dot_abs   = dot_reg[fsc_pkg::DOT_W-1] ? -dot_reg : dot_reg;
    assign dl        = mag_reg[HW-1:0];
    assign dh        = mag_reg[2*HW-1:HW];
    assign rl        = rad2_3_reg[RH_W-1:0];
    assign rh        = rad2_3_reg[2*RH_W-1:RH_W];
    assign sl        = s[SH_W-1:0];
    assign sh        = s[2*SH_W-1:SH_W];

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            p0_reg     <= k[0] * cx;
            p1_reg     <= k[1] * cy;
            p2_reg     <= k[2] * cz;
            kd_reg     <= k3x <<< FRAC_BITS;
            rad2_1_reg <= rad2_full;

            dot_reg    <= fsc_pkg::DOT_W'(p0_reg) + fsc_pkg::DOT_W'(p1_reg)
                        + fsc_pkg::DOT_W'(p2_reg) + kd_reg;
            rad2_2_reg <= rad2_1_reg;

            mag_reg    <= dot_abs[fsc_pkg::MAG_W-1:0];
            neg3_reg   <= dot_reg[fsc_pkg::DOT_W-1];
            rad2_3_reg <= rad2_2_reg;

            ll_reg     <= dl * dl;
            hl_reg     <= dh * dl;
            hh_reg     <= dh * dh;
            rlsl_reg   <= PP_W'(rl) * PP_W'(sl);
            rlsh_reg   <= PP_W'(rl) * PP_W'(sh);
            rhsl_reg   <= PP_W'(rh) * PP_W'(sl);
            rhsh_reg   <= PP_W'(rh) * PP_W'(sh);
            neg4_reg   <= neg3_reg;

            d2_reg     <= (fsc_pkg::D2_W'(hh_reg) << (2 * HW))
                        + (fsc_pkg::D2_W'(hl_reg) << (HW + 1))
                        + fsc_pkg::D2_W'(ll_reg);
            lhs_reg    <= (fsc_pkg::LHS_W'(rhsh_reg) << (RH_W + SH_W))
                        + (fsc_pkg::LHS_W'(rhsl_reg) << RH_W)
                        + (fsc_pkg::LHS_W'(rlsh_reg) << SH_W)
                        + fsc_pkg::LHS_W'(rlsl_reg);
            neg5_reg   <= neg4_reg;

            cull_reg   <= neg5_reg && (fsc_pkg::D2_W'(lhs_reg) < d2_reg);
        end
    end

    assign cull = cull_reg;

endmodule

// ----- src/frustum_sphere_cull.sv -----
// Top level of the frustum sphere cull block: input stage, plane lanes, output.
// Depends on fsc_pkg, fsc_coef and fsc_plane.
//
// Tests one bounding sphere per clock against the six planes of a view-projection
// matrix and reports visible = 0 when the sphere lies wholly behind any plane. A
// word is accepted on every cycle in which in_valid is high and in_stall is low,
// so the sustained rate is one sphere per cycle. A word is loaded into the input
// register at the edge that takes it and then passes the six stages of each plane
// lane, seven registers in all. The lane depth is set by the 33x33-bit partial
// products that square the plane distance. All six planes run side by side in
// their own lanes. The plane coefficients and their squared norms are derived
// from the matrix registers in a three-register chain, so the input is held off
// while that chain settles after reset and after every configuration write. The
// configuration port is always ready; writes to an index past the last register
// are dropped. When out_stall holds the output word, the whole pipeline freezes
// and in_stall rises.
module frustum_sphere_cull
#(
    parameter int FRAC_BITS = fsc_pkg::FRAC_BITS_DEF
)
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    output logic                               in_stall,
    input  logic signed [fsc_pkg::CTR_W-1:0]   center_x,
    input  logic signed [fsc_pkg::CTR_W-1:0]   center_y,
    input  logic signed [fsc_pkg::CTR_W-1:0]   center_z,
    input  logic        [fsc_pkg::RAD_W-1:0]   sphere_radius,
    output logic                               out_valid,
    input  logic                               out_stall,
    output logic                               visible,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [fsc_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [fsc_pkg::CFG_W-1:0]          cfg_data
);

    localparam int DEPTH = fsc_pkg::PLANE_LAT + 1;

    logic                               adv;
    logic                               busy;
    logic [DEPTH-1:0]                   vld_reg;
    logic signed [fsc_pkg::CTR_W-1:0]   cx_reg, cy_reg, cz_reg;
    logic [fsc_pkg::RAD_W-1:0]          rad_reg;
    fsc_pkg::coef_t                     coef [fsc_pkg::NUM_PLANES][fsc_pkg::NUM_ROWS];
    fsc_pkg::norm_t                     norm [fsc_pkg::NUM_PLANES];
    logic [fsc_pkg::NUM_PLANES-1:0]     cull;

    // The pipeline moves whenever the output word is empty or being taken.
    assign adv       = !vld_reg[DEPTH-1] || !out_stall;
    assign in_stall  = !adv || busy;
    assign cfg_ready = 1'b1;

    fsc_coef u_coef
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (cfg_valid && cfg_ready),
        .wr_index (cfg_index),
        .wr_data  (cfg_data),
        .coef     (coef),
        .norm     (norm),
        .busy     (busy)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (adv)
        begin
            vld_reg <= {vld_reg[DEPTH-2:0], in_valid && !busy};
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            cx_reg  <= center_x;
            cy_reg  <= center_y;
            cz_reg  <= center_z;
            rad_reg <= sphere_radius;
        end
    end

    genvar p;
    generate
        for (p = 0; p < fsc_pkg::NUM_PLANES; p++)
        begin : g_lane
            fsc_plane #(.FRAC_BITS(FRAC_BITS)) u_plane
            (
                .clk  (clk),
                .adv  (adv),
                .k    (coef[p]),
                .s    (norm[p]),
                .cx   (cx_reg),
                .cy   (cy_reg),
                .cz   (cz_reg),
                .rad  (rad_reg),
                .cull (cull[p])
            );
        end
    endgenerate

    // A sphere is visible unless at least one plane culls it.
    assign out_valid = vld_reg[DEPTH-1];
    assign visible   = ~|cull;

    // No word may enter while the derived coefficients are still settling.
    assert property (@(posedge clk) disable iff (!rst_n)
        !(in_valid && !in_stall && busy))
        else $error("word accepted while coefficients settle");

    // A configuration write holds off the input on the following cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        (cfg_valid && cfg_ready) |=> in_stall)
        else $error("input not held off after configuration write");

    // A held output word freezes the pipeline and blocks the input.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |-> in_stall)
        else $error("input open while output is held");

    // An accepted word occupies the first pipeline stage next cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> vld_reg[0])
        else $error("accepted word lost at pipeline entry");

endmodule

// ----- sim/testbench.sv -----
// Self-checking testbench for the frustum sphere cull block.
// Depends on src/fsc_pkg.sv and src/frustum_sphere_cull.sv; reads no files.
`timescale 1ns / 100ps

module testbench;
    import fsc_pkg::*;

    // Register indexes of the matrix configuration.
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_ROW1_A = 8'd0, REG_ROW1_B = 8'd1, REG_ROW2_A = 8'd2, REG_ROW2_B = 8'd3,
        REG_ROW3_A = 8'd4, REG_ROW3_B = 8'd5, REG_ROW4_A = 8'd6, REG_ROW4_B = 8'd7,
        REG_PAST_END = 8'd8, REG_TOP_INDEX = 8'd255
    } cfg_reg_e;

    localparam int FRAC       = FRAC_BITS_DEF;
    localparam int CYCLE_CAP  = 600000;
    localparam int DRAIN_WAIT = 20;
    localparam int ERR_SHOWN  = 10;
    localparam int RAND_ITEMS = 144;
    localparam int NUM_PHASES = 10;

    localparam logic signed [CTR_W-1:0] ONE   = 32'sh0001_0000;
    localparam logic signed [CTR_W-1:0] S_MAX = 32'sh7fff_ffff;
    localparam logic signed [CTR_W-1:0] S_MIN = 32'sh8000_0000;
    localparam logic [RAD_W-1:0]        R_ONE = 31'h0001_0000;
    localparam logic [RAD_W-1:0]        R_MAX = 31'h7fff_ffff;

    typedef struct packed {
        logic signed [CTR_W-1:0] x;
        logic signed [CTR_W-1:0] y;
        logic signed [CTR_W-1:0] z;
        logic [RAD_W-1:0]        r;
        logic                    typed;  // expected value below is fixed by hand
        logic                    vis;
    } sphere_row_t;

    // Directed spheres, all run against the identity matrix found after reset.
    // With it the planes are x >= -1, x <= 1, y >= -1, y <= 1, z >= 0, z <= 1.
    localparam int NUM_DIRECTED = 14;
    localparam sphere_row_t DIRECTED [NUM_DIRECTED] = '{
        '{32'sh0, 32'sh0, 32'sh0, 31'h0, 1'b1, 1'b1},
        '{-2 * ONE, 32'sh0, 32'sh0, 31'h0, 1'b1, 1'b0},
        '{-2 * ONE, 32'sh0, 32'sh0, R_ONE, 1'b1, 1'b1},  // touches left plane
        '{2 * ONE, 32'sh0, 32'sh0, R_ONE, 1'b1, 1'b1},   // touches right plane
        '{32'sh0, 32'sh0, -ONE, 31'h0, 1'b1, 1'b0},      // behind near plane
        '{32'sh0, 32'sh0, ONE / 2, 31'h0, 1'b1, 1'b1},
        '{32'sh0, 32'sh0, 2 * ONE, 31'h0, 1'b1, 1'b0},   // beyond far plane
        '{32'sh0, -3 * ONE, 32'sh0, R_ONE, 1'b1, 1'b0},
        '{S_MIN, S_MIN, S_MIN, 31'h0, 1'b1, 1'b0},
        '{32'sh0, 32'sh0, 32'sh0, R_MAX, 1'b1, 1'b1},
        '{S_MAX, S_MIN, S_MAX, R_MAX, 1'b0, 1'b0},
        '{-32'sh1, -32'sh1, -32'sh1, 31'h1, 1'b0, 1'b0},
        '{S_MIN, S_MAX, 32'sh5555_5555, 31'h2aaa_aaaa, 1'b0, 1'b0},
        '{32'shaaaa_aaaa, 32'sh5555_5555, 32'shaaaa_aaaa, 31'h5555_5555, 1'b0, 1'b0}
    };

    logic                    clk;
    logic                    rst_n;
    logic                    in_valid;
    logic                    in_stall;
    logic signed [CTR_W-1:0] center_x;
    logic signed [CTR_W-1:0] center_y;
    logic signed [CTR_W-1:0] center_z;
    logic [RAD_W-1:0]        sphere_radius;
    logic                    out_valid;
    logic                    out_stall;
    logic                    visible;
    logic                    cfg_valid;
    logic                    cfg_ready;
    logic [CFG_IDX_W-1:0]    cfg_index;
    logic [CFG_W-1:0]        cfg_data;

    // Local copy of the matrix registers and the queue of expected visibility bits.
    logic [CFG_W-1:0] matrix_regs [NUM_CFG];
    logic             visible_queue [$];

    int cycles;
    int mismatches;
    int spheres_sent;
    int results_seen;
    int culled_seen;
    int burst_left;

    frustum_sphere_cull dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .center_x      (center_x),
        .center_y      (center_y),
        .center_z      (center_z),
        .sphere_radius (sphere_radius),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .visible       (visible),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // Matrix entry M[row][col] with zero-based row and column.
    function automatic logic signed [ENT_W-1:0] matrix_entry(input int row, input int col);
        logic [CFG_W-1:0] word;
        word = matrix_regs[2 * row + (col > 1 ? 1 : 0)];
        return (col % 2 == 1) ? word[63:32] : word[31:0];
    endfunction

    // Exact sphere test against the six planes. A plane culls when its
    // distance is negative and radius^2 * |n|^2 < distance^2, which is the
    // squared form of distance + radius * |n| < 0 and needs no square root.
    function automatic logic sphere_visible(input logic signed [CTR_W-1:0] cx,
                                            input logic signed [CTR_W-1:0] cy,
                                            input logic signed [CTR_W-1:0] cz,
                                            input logic [RAD_W-1:0] rad);
        logic signed [255:0] k [NUM_ROWS];
        logic signed [255:0] plane_dist;
        logic signed [255:0] norm2;
        logic signed [255:0] rad2;
        for (int p = 0; p < NUM_PLANES; p++)
        begin
            for (int r = 0; r < NUM_ROWS; r++)
            begin
                k[r] = 0;
                if (PLANE_W4[p])
                    k[r] = matrix_entry(r, 3);
                if (PLANE_NEG[p])
                    k[r] = k[r] - matrix_entry(r, PLANE_COL[p]);
                else
                    k[r] = k[r] + matrix_entry(r, PLANE_COL[p]);
            end
            plane_dist = k[0] * cx + k[1] * cy + k[2] * cz + (k[3] <<< FRAC);
            norm2      = k[0] * k[0] + k[1] * k[1] + k[2] * k[2];
            rad2       = rad;
            rad2       = rad2 * rad2;
            if (plane_dist < 0 && rad2 * norm2 < plane_dist * plane_dist)
                return 1'b0;
        end
        return 1'b1;
    endfunction

    // Drives one configuration word and mirrors it into the local registers if its index is in range.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
        @(negedge clk);
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data  = data;
        do
            @(posedge clk);
        while (!cfg_ready);
        if (idx < NUM_CFG)
            matrix_regs[idx] = data;
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    // Offers one sphere; the sender keeps valid high inside a burst and,
    // if gaps is set, drops it for a random gap between bursts. The
    // expected bit is queued at the edge where the word is taken.
    task automatic send_sphere(input logic signed [CTR_W-1:0] cx,
                               input logic signed [CTR_W-1:0] cy,
                               input logic signed [CTR_W-1:0] cz,
                               input logic [RAD_W-1:0] rad,
                               input logic typed, input logic typed_vis,
                               input bit gaps);
        int gap;
        @(negedge clk);
        if (gaps && burst_left == 0)
        begin
            in_valid = 1'b0;
            gap = $urandom_range(1, 6);
            repeat (gap - 1) @(negedge clk);
            burst_left = $urandom_range(1, 24);
        end
        in_valid      = 1'b1;
        center_x      = cx;
        center_y      = cy;
        center_z      = cz;
        sphere_radius = rad;
        do
            @(posedge clk);
        while (in_stall);
        visible_queue.push_back(typed ? typed_vis : sphere_visible(cx, cy, cz, rad));
        spheres_sent++;
        if (burst_left > 0)
            burst_left--;
    endtask

    // Waits until every queued result has come back, then lets the pipe empty.
    task automatic wait_idle();
        @(negedge clk);
        in_valid = 1'b0;
        while (visible_queue.size() != 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);
    endtask

    function automatic logic [ENT_W-1:0] random_entry(input int flavor);
        case (flavor)
            0: return $urandom;
            default: return $urandom_range(0, 8 * 65536) - 4 * 65536;
        endcase
    endfunction

    function automatic logic signed [CTR_W-1:0] random_coord(input int flavor);
        case (flavor)
            0: return $urandom;
            1: return ($urandom_range(0, 1) == 1) ? S_MAX : S_MIN;
            default: return $urandom_range(0, 16 * 65536) - 8 * 65536;
        endcase
    endfunction

    // Loads one matrix per phase: the extremes, the degenerate cases and
    // random matrices, every register written each time.
    task automatic load_phase_matrix(input int phase);
        logic [ENT_W-1:0] e [NUM_ROWS][NUM_ROWS];
        int flavor;
        flavor = $urandom_range(0, 2);
        for (int r = 0; r < NUM_ROWS; r++)
            for (int c = 0; c < NUM_ROWS; c++)
                case (phase)
                    1: e[r][c] = '0;  // every plane degenerate with zero offset
                    2: e[r][c] = (r == 3 && c == 3) ? -ONE : '0;  // degenerate, offset -1 or 0
                    3: e[r][c] = '1;
                    4: e[r][c] = S_MAX;
                    5: e[r][c] = S_MIN;
                    default: e[r][c] = random_entry(flavor == 0 ? 0 : 1);
                endcase
        write_reg(REG_PAST_END, {$urandom, $urandom});
        for (int r = 0; r < NUM_ROWS; r++)
        begin
            write_reg(cfg_reg_e'(2 * r), {e[r][1], e[r][0]});
            write_reg(cfg_reg_e'(2 * r + 1), {e[r][3], e[r][2]});
        end
        write_reg(REG_TOP_INDEX, {$urandom, $urandom});
    endtask

    // The receiver switches at random between stall patterns,
    // including stretches with no stall at all.
    initial
    begin
        int pattern;
        out_stall = 1'b0;
        pattern   = 0;
        forever
        begin
            @(negedge clk);
            if (cycles % 128 == 0)
                pattern = $urandom_range(0, 3);
            case (pattern)
                0: out_stall = 1'b0;
                1: out_stall = ($urandom_range(0, 3) == 0);
                2: out_stall = ($urandom_range(0, 9) < 7);
                default: out_stall = (cycles % 5 == 0);
            endcase
        end
    end

    // Result checker: every accepted word is matched against the oldest
    // expectation.
    always @(posedge clk)
    begin
        logic want;
        if (rst_n && out_valid && !out_stall)
        begin
            results_seen++;
            if (!visible)
                culled_seen++;
            if (visible_queue.size() == 0)
            begin
                mismatches++;
                if (mismatches <= ERR_SHOWN)
                    $display("ERROR: result visible=%0b with nothing expected, cycle %0d",
                             visible, cycles);
            end
            else
            begin
                want = visible_queue.pop_front();
                if (visible !== want)
                begin
                    mismatches++;
                    if (mismatches <= ERR_SHOWN)
                        $display("ERROR: visible expected %0b, got %0b, cycle %0d",
                                 want, visible, cycles);
                end
            end
        end
    end

    // Watchdog on the whole run.
    always @(posedge clk)
    begin
        cycles++;
        if (cycles >= CYCLE_CAP)
        begin
            $display("ERROR: run timed out after %0d cycles", cycles);
            $display("testbench NOT OK");
            $finish;
        end
    end

    initial
    begin
        int flavor;
        logic signed [CTR_W-1:0] cx;
        logic signed [CTR_W-1:0] cy;
        logic signed [CTR_W-1:0] cz;
        logic [RAD_W-1:0] rad;
        bit gaps;
        cycles        = 0;
        mismatches    = 0;
        spheres_sent  = 0;
        results_seen  = 0;
        culled_seen   = 0;
        burst_left    = 0;
        rst_n         = 1'b0;
        in_valid      = 1'b0;
        center_x      = '0;
        center_y      = '0;
        center_z      = '0;
        sphere_radius = '0;
        cfg_valid     = 1'b0;
        cfg_index     = '0;
        cfg_data      = '0;
        for (int i = 0; i < NUM_CFG; i++)
            matrix_regs[i] = CFG_RESET[i];
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed rows run back to back against the reset matrix.
        for (int i = 0; i < NUM_DIRECTED; i++)
            send_sphere(DIRECTED[i].x, DIRECTED[i].y, DIRECTED[i].z, DIRECTED[i].r,
                        DIRECTED[i].typed, DIRECTED[i].vis, 1'b0);

        for (int phase = 0; phase < NUM_PHASES; phase++)
        begin
            if (phase > 0)
            begin
                wait_idle();
                load_phase_matrix(phase);
            end
            gaps = (phase % 3 != 0);
            for (int n = 0; n < RAND_ITEMS; n++)
            begin
                // Mostly small spheres near the frustum, where the answer is
                // close; the rest full-range or extreme values.
                flavor = $urandom_range(0, 9);
                if (flavor < 2)
                begin
                    cx  = random_coord(0);
                    cy  = random_coord(0);
                    cz  = random_coord(0);
                    rad = $urandom;
                end
                else if (flavor == 2)
                begin
                    cx  = random_coord(1);
                    cy  = random_coord(1);
                    cz  = random_coord(1);
                    rad = ($urandom_range(0, 1) == 1) ? R_MAX : '0;
                end
                else
                begin
                    cx  = random_coord(2);
                    cy  = random_coord(2);
                    cz  = random_coord(2);
                    rad = $urandom_range(0, 4 * 65536);
                end
                send_sphere(cx, cy, cz, rad, 1'b0, 1'b0, gaps);
            end
        end

        wait_idle();
        $display("Covered %0d spheres over %0d matrix settings; %0d results, %0d culled.",
                 spheres_sent, NUM_PHASES, results_seen, culled_seen);
        $display("Mismatches: %0d", mismatches);
        if (mismatches == 0)
            $display("testbench OK");
        else
            $display("testbench NOT OK");
        $finish;
    end

endmodule

// ----- filelist.f -----
src/fsc_pkg.sv
src/fsc_coef.sv
src/fsc_plane.sv
src/frustum_sphere_cull.sv
sim/testbench.sv
